>>> hw/rtl/cosfd_pkg.sv
// Shared types, constants and arithmetic helpers for the CO2 sensor frame decoder.
package cosfd_pkg;

   // CRC-8 over each word: polynomial 0x31, seed 0xFF, no final xor
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // Byte position of the last (humidity CRC) byte of a frame
   localparam logic [3:0] FRAME_LAST = 4'd8;

   // Conversion constants
   localparam logic [8:0]         TEMP_MUL        = 9'd315;
   localparam logic [24:0]        TEMP_OFFSET     = 25'd3211215;  // 49 * 65535
   localparam logic signed [12:0] TEMP_BIAS       = 13'sd49;
   localparam logic [9:0]         HUM_MUL         = 10'd1000;
   localparam logic [25:0]        FULL_SCALE_CEIL = 26'd65534;    // full scale minus one

   // Position within the current word
   typedef enum logic [1:0] {
      PH_HIGH,
      PH_LOW,
      PH_CHECK
   } word_phase_type;

   // Frame status from the frame tracker to the top level
   typedef struct packed {
      logic last;   // item in the input register closes a frame
      logic ok;     // all three word CRCs matched, valid with last
   } frame_status_type;

   // One byte through the CRC-8 shift register
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) for x below 1024 * 65535: (x + (x >> 16) + 1) >> 16
   function automatic logic [9:0] div_full_scale(input logic [25:0] x);
      logic [26:0] s;
      s = {1'b0, x} + 27'(x[25:16]) + 27'd1;
      return s[25:16];
   endfunction

endpackage

>>> hw/rtl/cosfd_if.sv
// Valid/ready channel interfaces for the frame byte input and the result output.
interface cosfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface cosfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_ok;
   logic [15:0]        co2_ppm;
   logic signed [12:0] temp_tenths_f;
   logic [9:0]         humidity_tenths;

   modport source (output valid, output frame_ok, output co2_ppm, output temp_tenths_f,
                   output humidity_tenths, input ready);
   modport sink   (input valid, input frame_ok, input co2_ppm, input temp_tenths_f,
                   input humidity_tenths, output ready);
endinterface

>>> hw/rtl/cosfd_frame_ctl.sv
// Frame tracker: byte position, per-word CRC check and raw word capture.
module cosfd_frame_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,        // item in the input register is consumed
   input  logic [7:0]                  rx_byte,
   input  logic                        frame_start,
   output cosfd_pkg::frame_status_type status,
   output logic [15:0]                 raw_co2,
   output logic [15:0]                 raw_temp,
   output logic [15:0]                 raw_hum
);
   import cosfd_pkg::*;

   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] co2_ff, co2_in;
   logic [15:0] temp_ff, temp_in;
   logic [15:0] hum_ff, hum_in;
   logic        failed_ff, failed_in;

   logic [3:0]     pos;
   word_phase_type phase;
   logic [15:0]    word;

   // Effective position of this byte: start mark or out-of-range restarts the frame
   always_comb begin
      pos = (frame_start || (pos_ff > FRAME_LAST)) ? 4'd0 : pos_ff;
      case (pos) inside
         4'd0, 4'd3, 4'd6: phase = PH_HIGH;
         4'd1, 4'd4, 4'd7: phase = PH_LOW;
         default:          phase = PH_CHECK;
      endcase
   end

   assign word = {high_ff, rx_byte};

   // Next state for one byte
   always_comb begin
      pos_in    = (pos == FRAME_LAST) ? 4'd0 : pos + 4'd1;
      crc_in    = crc_ff;
      high_in   = high_ff;
      co2_in    = co2_ff;
      temp_in   = temp_ff;
      hum_in    = hum_ff;
      failed_in = failed_ff;
      case (phase)
         PH_HIGH: begin
            crc_in  = crc_feed(CRC_INIT, rx_byte);
            high_in = rx_byte;
            if (pos == 4'd0) begin
               failed_in = 1'b0;
            end
         end
         PH_LOW: begin
            crc_in = crc_feed(crc_ff, rx_byte);
            case (pos)
               4'd1:    co2_in  = word;
               4'd4:    temp_in = word;
               default: hum_in  = word;
            endcase
         end
         default: begin
            if (crc_ff != rx_byte) begin
               failed_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         crc_ff    <= CRC_INIT;
         high_ff   <= 8'd0;
         co2_ff    <= 16'd0;
         temp_ff   <= 16'd0;
         hum_ff    <= 16'd0;
         failed_ff <= 1'b0;
      end else if (step) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         high_ff   <= high_in;
         co2_ff    <= co2_in;
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         failed_ff <= failed_in;
      end
   end

   // The last byte is the humidity CRC; all raw words are already captured
   assign status.last = (pos == FRAME_LAST);
   assign status.ok   = !failed_ff && (crc_ff == rx_byte);
   assign raw_co2     = co2_ff;
   assign raw_temp    = temp_ff;
   assign raw_hum     = hum_ff;

endmodule

>>> hw/rtl/cosfd_convert.sv
// Raw word to engineering unit conversion for temperature and humidity.
module cosfd_convert (
   input  logic [15:0]        raw_temp,
   input  logic [15:0]        raw_hum,
   output logic signed [12:0] temp_tenths_f,
   output logic [9:0]         humidity_tenths
);
   import cosfd_pkg::*;

   logic [24:0]        temp_scaled;
   logic [9:0]         quot_floor;
   logic [9:0]         quot_ceil;
   logic [9:0]         quot;
   logic signed [12:0] deg;
   logic [25:0]        hum_scaled;

   // Temperature: trunc(315*raw/65535 - 49) * 10; below the offset truncation
   // toward zero means taking the ceiling of the scaled quotient
   always_comb begin
      temp_scaled   = 25'(raw_temp * TEMP_MUL);
      quot_floor    = div_full_scale(26'(temp_scaled));
      quot_ceil     = div_full_scale(26'(temp_scaled) + FULL_SCALE_CEIL);
      quot          = (temp_scaled >= TEMP_OFFSET) ? quot_floor : quot_ceil;
      deg           = $signed({3'b000, quot}) - TEMP_BIAS;
      temp_tenths_f = (deg <<< 3) + (deg <<< 1);
   end

   // Humidity: floor(1000*raw/65535)
   always_comb begin
      hum_scaled      = 26'(raw_hum * HUM_MUL);
      humidity_tenths = div_full_scale(hum_scaled);
   end

endmodule

>>> hw/rtl/co2_sensor_frame_decoder.sv
// Top level of the CO2 sensor measurement frame decoder.
// Takes a 9-byte measurement frame one byte per item (three big-endian words, CO2,
// temperature and humidity, each followed by a CRC-8 with polynomial 0x31 and seed
// 0xFF) and gives one result item after the ninth byte: the CRC verdict and the held
// readings, which are refreshed only by a good frame. frame_start restarts the frame
// at the current byte; without it frames may follow back to back. One byte is taken
// every cycle: a byte sits in the input register, where the CRC step and the
// constant-multiply conversions are done, and a frame's result enters the output
// register as its last byte leaves. Only a result waiting in the output register while a
// frame's last byte is ready to complete holds off the input.
module co2_sensor_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   cosfd_req_if.sink   req_chan,
   cosfd_rsp_if.source rsp_chan
);
   import cosfd_pkg::*;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // Held readings
   logic [15:0]        held_co2_ff, held_co2_in;
   logic signed [12:0] held_temp_ff, held_temp_in;
   logic [9:0]         held_hum_ff, held_hum_in;

   // Output register
   logic               out_valid_ff, out_valid_in;
   logic               out_ok_ff;
   logic [15:0]        out_co2_ff;
   logic signed [12:0] out_temp_ff;
   logic [9:0]         out_hum_ff;

   frame_status_type   status;
   logic [15:0]        raw_co2;
   logic [15:0]        raw_temp;
   logic [15:0]        raw_hum;
   logic signed [12:0] conv_temp;
   logic [9:0]         conv_hum;
   logic               advance;
   logic               take;
   logic               emit;

   // Item in the input register moves on unless it closes a frame and the
   // output register holds a result that is not being taken
   assign advance = in_valid_ff && (!status.last || !out_valid_ff || rsp_chan.ready);
   assign emit    = advance && status.last;
   assign take    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   cosfd_frame_ctl u_frame_ctl (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .frame_start (in_start_ff),
      .status      (status),
      .raw_co2     (raw_co2),
      .raw_temp    (raw_temp),
      .raw_hum     (raw_hum)
   );

   cosfd_convert u_convert (
      .raw_temp        (raw_temp),
      .raw_hum         (raw_hum),
      .temp_tenths_f   (conv_temp),
      .humidity_tenths (conv_hum)
   );

   // Next held readings: a good frame replaces them
   always_comb begin
      held_co2_in  = held_co2_ff;
      held_temp_in = held_temp_ff;
      held_hum_in  = held_hum_ff;
      if (status.ok) begin
         held_co2_in  = raw_co2;
         held_temp_in = conv_temp;
         held_hum_in  = conv_hum;
      end
   end

   // Valid flags
   always_comb begin
      in_valid_in = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         held_co2_ff  <= 16'd0;
         held_temp_ff <= 13'sd0;
         held_hum_ff  <= 10'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (emit) begin
            held_co2_ff  <= held_co2_in;
            held_temp_ff <= held_temp_in;
            held_hum_ff  <= held_hum_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff  <= req_chan.rx_byte;
         in_start_ff <= req_chan.frame_start;
      end
      if (emit) begin
         out_ok_ff   <= status.ok;
         out_co2_ff  <= held_co2_in;
         out_temp_ff <= held_temp_in;
         out_hum_ff  <= held_hum_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.frame_ok        = out_ok_ff;
   assign rsp_chan.co2_ppm         = out_co2_ff;
   assign rsp_chan.temp_tenths_f   = out_temp_ff;
   assign rsp_chan.humidity_tenths = out_hum_ff;

endmodule

>>> bench/co2_sensor_frame_decoder_test.sv
// Self-checking testbench for the CO2 sensor frame decoder: directed frames, then random byte streams.
`timescale 1ns / 100ps

module co2_sensor_frame_decoder_test;
   import cosfd_pkg::CRC_INIT;
   import cosfd_pkg::CRC_POLY;
   import cosfd_pkg::FRAME_LAST;
   import cosfd_pkg::word_phase_type;
   import cosfd_pkg::PH_HIGH;
   import cosfd_pkg::PH_LOW;

   localparam int ITEM_TOTAL    = 1550;
   localparam int STEADY_TAIL   = 200;   // final items run with no idling
   localparam int STALL_LIMIT   = 1000;  // cycles without any accepted item
   localparam int SETTLE_CYCLES = 16;
   localparam int WORD_CO2      = 0;
   localparam int WORD_TEMP     = 1;

   typedef struct {
      logic               frame_ok;
      logic [15:0]        co2_ppm;
      logic signed [12:0] temp_tenths_f;
      logic [9:0]         humidity_tenths;
   } reading_type;

   typedef struct {
      logic [7:0]  rx_byte;
      logic        frame_start;
      bit          typed;      // reading below replaces the predicted one
      reading_type want;
   } frame_byte_row_type;

   localparam reading_type NO_READING     = '{1'b0, 16'd0, 13'sd0, 10'd0};
   localparam reading_type ZERO_WORDS     = '{1'b1, 16'd0, -13'sd490, 10'd0};
   localparam reading_type FULL_WORDS     = '{1'b1, 16'd65535, 13'sd2660, 10'd1000};
   localparam reading_type FULL_HELD_BAD  = '{1'b0, 16'd65535, 13'sd2660, 10'd1000};

   logic clock;
   logic reset;
   bit   steady;
   int   items_sent;
   int   mismatches;
   int   idle_cycles;

   cosfd_req_if req_bus ();
   cosfd_rsp_if rsp_bus ();

   co2_sensor_frame_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Directed frames: all-zero words, all-ones words back to back without a start
   // mark, a frame cut short by a start mark, then a bad humidity CRC
   frame_byte_row_type directed_rows [29] = '{
      '{8'h00, 1'b1, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h81, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h81, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b0, NO_READING}, '{8'h00, 1'b0, 1'b0, NO_READING},
      '{8'h81, 1'b0, 1'b1, ZERO_WORDS},
      '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hAC, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hAC, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hAC, 1'b0, 1'b1, FULL_WORDS},
      '{8'h12, 1'b1, 1'b0, NO_READING}, '{8'h34, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b1, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hAC, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hAC, 1'b0, 1'b0, NO_READING},
      '{8'hFF, 1'b0, 1'b0, NO_READING}, '{8'hFF, 1'b0, 1'b0, NO_READING},
      '{8'h00, 1'b0, 1'b1, FULL_HELD_BAD}
   };

   // Bytes handed to the bus but not yet accepted, and readings still to arrive
   frame_byte_row_type bytes_in_flight [$];
   reading_type        readings_due [$];

   // Decoder state as seen by the predictor
   logic [3:0]         frame_pos    = 4'd0;
   logic [7:0]         word_crc     = CRC_INIT;
   logic [7:0]         high_byte    = 8'd0;
   logic [15:0]        raw_co2      = 16'd0;
   logic [15:0]        raw_temp     = 16'd0;
   logic [15:0]        raw_hum      = 16'd0;
   logic               frame_bad    = 1'b0;
   logic [15:0]        held_co2     = 16'd0;
   logic signed [12:0] held_temp    = 13'sd0;
   logic [9:0]         held_hum     = 10'd0;

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
      return c;
   endfunction

   // Advance the frame by one byte; a closing byte yields a reading
   task automatic decode_frame_byte(input logic [7:0] b, input logic start,
                                    output bit closes, output reading_type r);
      logic [3:0]     at;
      word_phase_type phase;
      longint         scaled;
      at = start ? 4'd0 : frame_pos;
      if (at > FRAME_LAST) at = 4'd0;
      if (at == 4'd0) frame_bad = 1'b0;
      phase = word_phase_type'(2'(at % 3));
      case (phase)
         PH_HIGH: begin
            word_crc  = crc8_step(CRC_INIT, b);
            high_byte = b;
         end
         PH_LOW: begin
            word_crc = crc8_step(word_crc, b);
            if (at / 3 == WORD_CO2) raw_co2 = {high_byte, b};
            else if (at / 3 == WORD_TEMP) raw_temp = {high_byte, b};
            else raw_hum = {high_byte, b};
         end
         default: begin
            if (word_crc != b) frame_bad = 1'b1;
         end
      endcase
      closes = (at == FRAME_LAST);
      frame_pos = closes ? 4'd0 : at + 4'd1;
      r = NO_READING;
      if (closes) begin
         if (!frame_bad) begin
            held_co2  = raw_co2;
            // -49 F + 315 F full scale, whole degrees truncated toward zero
            scaled    = 64'sd315 * longint'(raw_temp) - 64'sd49 * 64'sd65535;
            held_temp = 13'((scaled / 64'sd65535) * 10);
            held_hum  = 10'((32'd1000 * raw_hum) / 32'd65535);
         end
         r = '{!frame_bad, held_co2, held_temp, held_hum};
      end
   endtask

   task automatic compare_field(input string field, input integer want, input integer got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Maybe idle, then put one byte on the bus and wait for it to be taken
   task automatic send_byte(input logic [7:0] b, input logic start,
                            input bit typed, input reading_type want);
      frame_byte_row_type row;
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      row = '{b, start, typed, want};
      bytes_in_flight.push_back(row);
      req_bus.valid       <= 1'b1;
      req_bus.rx_byte     <= b;
      req_bus.frame_start <= start;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Raw words lean toward the extremes and the temperature zero crossing
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(9900, 10500));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: ready drops in bursts, held high once the tail begins
   initial begin
      forever begin
         if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Monitor: predict on each accepted byte, check each accepted reading
   always @(posedge clock) begin
      frame_byte_row_type taken;
      reading_type        want;
      bit                 closes;
      bit                 moved;
      moved = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         taken = bytes_in_flight.pop_front();
         decode_frame_byte(taken.rx_byte, taken.frame_start, closes, want);
         if (closes) readings_due.push_back(taken.typed ? taken.want : want);
         moved = 1'b1;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         if (readings_due.size() == 0) begin
            $display("%0t: unexpected reading, expected none, actual ok=%0d co2=%0d",
                     $time, rsp_bus.frame_ok, rsp_bus.co2_ppm);
            mismatches++;
         end else begin
            want = readings_due.pop_front();
            compare_field("frame_ok", want.frame_ok, rsp_bus.frame_ok);
            compare_field("co2_ppm", want.co2_ppm, rsp_bus.co2_ppm);
            compare_field("temp_tenths_f", want.temp_tenths_f, rsp_bus.temp_tenths_f);
            compare_field("humidity_tenths", want.humidity_tenths, rsp_bus.humidity_tenths);
         end
      end
      // watchdog
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, nothing accepted for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      logic [7:0]  frame_bytes [9];
      logic [15:0] w;
      bit          need_start;
      int          pick;
      int          cut;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.rx_byte     <= 8'h00;
      req_bus.frame_start <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].frame_start,
                   directed_rows[i].typed, directed_rows[i].want);

      // hold the sender until every reading so far has come back
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (readings_due.size() != 0);

      need_start = 1'b1;
      while (items_sent < ITEM_TOTAL) begin
         if (items_sent >= ITEM_TOTAL - STEADY_TAIL) steady = 1'b1;
         pick = $urandom_range(0, 99);
         for (int k = 0; k < 3; k++) begin
            w = pick_word();
            frame_bytes[3 * k]     = w[15:8];
            frame_bytes[3 * k + 1] = w[7:0];
            frame_bytes[3 * k + 2] = crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
         end
         if (pick < 90) begin
            // well-formed frame, one byte corrupted in some of them
            if (pick >= 75) begin
               cut = $urandom_range(0, 8);
               frame_bytes[cut] ^= 8'($urandom_range(1, 255));
            end
            for (int k = 0; k < 9; k++)
               send_byte(frame_bytes[k], k == 0 && (need_start || $urandom_range(0, 1)),
                         1'b0, NO_READING);
            need_start = 1'b0;
         end else if (pick < 95) begin
            // frame broken off partway
            cut = $urandom_range(1, 8);
            for (int k = 0; k < cut; k++)
               send_byte(frame_bytes[k], k == 0, 1'b0, NO_READING);
            need_start = 1'b1;
         end else begin
            // noise bytes with stray start marks
            repeat ($urandom_range(1, 5))
               send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, NO_READING);
            need_start = 1'b1;
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (readings_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && readings_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cosfd_pkg.sv
hw/rtl/cosfd_if.sv
hw/rtl/cosfd_frame_ctl.sv
hw/rtl/cosfd_convert.sv
hw/rtl/co2_sensor_frame_decoder.sv
bench/co2_sensor_frame_decoder_test.sv
